/* hw/rtl/csvtok_pkg.sv */
`default_nettype none

package csvtok_pkg;

    // Result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FIRST_SEP  = 2'd0;
    localparam logic [1:0] CFG_SECOND_SEP = 2'd1;
    localparam logic [1:0] CFG_QUOTE      = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] RST_FIRST_SEP  = 8'd59;
    localparam logic [7:0] RST_SECOND_SEP = 8'd44;
    localparam logic [7:0] RST_QUOTE      = 8'd34;

    localparam logic [7:0] CH_CR = 8'd13;
    localparam logic [7:0] CH_LF = 8'd10;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

endpackage

`default_nettype wire

/* hw/rtl/csv_record_tokenizer_unit.sv */
// CSV record tokenizer. Each request carries one byte of a CSV stream (or an
// end-of-input command) and produces zero, one or two results: field bytes,
// end-of-field marks and end-of-record marks, the last result of a request
// flagged by last_of_run. Quoted values, doubled quotes, LF, CR-LF and lone
// CR line ends are handled; separators and the quote byte are programmable
// through the write port, which the user must use only while the block is
// idle; the block itself does not enforce this. Results are registered into
// a queue, and the block accepts one request per cycle as long as its 4-entry
// result queue has room for two results, so a stream that yields at most one
// result per byte runs at one byte per cycle while the output is not stalled,
// and bytes that yield two results fill the queue up and can hold off input.
`default_nettype none

module csv_record_tokenizer_unit
    import csvtok_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in        i_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out            o_out
);

    logic [7:0] r_first_sep;
    logic [7:0] r_second_sep;
    logic [7:0] r_quote;

    logic r_quoted, r_val_empty, r_rec_open, r_crp, r_qcp;
    logic n_quoted, n_val_empty, n_rec_open, n_crp, n_qcp;

    t_out       w_res [2];
    logic [1:0] w_res_n;

    t_out       r_fifo [4];
    logic [1:0] r_rd_ptr, r_wr_ptr;
    logic [2:0] r_count;
    logic [2:0] n_count;

    logic w_accept;
    logic w_pop;

    assign o_in_ready  = (r_count <= 3'd2);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 3'd0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_out       = r_fifo[r_rd_ptr];

    // Tokenizer step: next flags and up to two results for the current request
    always_comb begin
        logic [7:0] c;
        logic       done;
        logic       handled;
        c           = i_in.data_byte;
        done        = 1'b0;
        handled     = 1'b0;
        n_quoted    = r_quoted;
        n_val_empty = r_val_empty;
        n_rec_open  = r_rec_open;
        n_crp       = r_crp;
        n_qcp       = r_qcp;
        w_res_n     = 2'd0;
        w_res[0]    = '0;
        w_res[1]    = '0;

        if (i_in.cmd) begin
            if (n_qcp) begin
                n_qcp    = 1'b0;
                n_quoted = 1'b0;
            end
            if (n_crp) begin
                n_crp = 1'b0;
                if (n_quoted) begin
                    n_val_empty = 1'b0;
                    n_rec_open  = 1'b1;
                    if (w_res_n != 2'd2) begin
                        w_res[w_res_n[0]].kind     = KIND_BYTE;
                        w_res[w_res_n[0]].out_byte = CH_LF;
                        w_res_n = w_res_n + 2'd1;
                    end
                end else begin
                    n_quoted    = 1'b0;
                    n_val_empty = 1'b1;
                    n_rec_open  = 1'b0;
                    if (w_res_n != 2'd2) begin
                        w_res[w_res_n[0]].kind = KIND_RECORD;
                        w_res_n = w_res_n + 2'd1;
                    end
                end
            end
            if (n_rec_open) begin
                if (w_res_n != 2'd2) begin
                    w_res[w_res_n[0]].kind = KIND_RECORD;
                    w_res_n = w_res_n + 2'd1;
                end
            end
            n_quoted    = 1'b0;
            n_val_empty = 1'b1;
            n_rec_open  = 1'b0;
        end else begin
            // Held quote: a second quote is a literal, anything else closes quoting
            if (n_qcp) begin
                n_qcp = 1'b0;
                if (c == r_quote) begin
                    n_val_empty = 1'b0;
                    w_res[w_res_n[0]].kind     = KIND_BYTE;
                    w_res[w_res_n[0]].out_byte = c;
                    w_res_n = w_res_n + 2'd1;
                    done    = 1'b1;
                end else begin
                    n_quoted = 1'b0;
                end
            end
            if (!done) begin
                // Held CR: drop it before LF, else treat it as a newline
                if (n_crp) begin
                    n_crp = 1'b0;
                    if (c != CH_LF) begin
                        if (n_quoted) begin
                            n_val_empty = 1'b0;
                            n_rec_open  = 1'b1;
                            w_res[w_res_n[0]].kind     = KIND_BYTE;
                            w_res[w_res_n[0]].out_byte = CH_LF;
                            w_res_n = w_res_n + 2'd1;
                        end else begin
                            n_quoted    = 1'b0;
                            n_val_empty = 1'b1;
                            n_rec_open  = 1'b0;
                            w_res[w_res_n[0]].kind = KIND_RECORD;
                            w_res_n = w_res_n + 2'd1;
                        end
                    end
                end
                if (c == CH_CR) begin
                    n_crp      = 1'b1;
                    n_rec_open = 1'b1;
                end else begin
                    n_rec_open = 1'b1;
                    if (c == r_quote) begin
                        if (n_quoted) begin
                            n_qcp   = 1'b1;
                            handled = 1'b1;
                        end else if (n_val_empty) begin
                            n_quoted = 1'b1;
                            handled  = 1'b1;
                        end
                    end
                    if (!handled && !n_quoted) begin
                        if (c == CH_LF) begin
                            n_quoted    = 1'b0;
                            n_val_empty = 1'b1;
                            n_rec_open  = 1'b0;
                            if (w_res_n != 2'd2) begin
                                w_res[w_res_n[0]].kind = KIND_RECORD;
                                w_res_n = w_res_n + 2'd1;
                            end
                            handled = 1'b1;
                        end else if (c == r_first_sep || c == r_second_sep) begin
                            n_val_empty = 1'b1;
                            if (w_res_n != 2'd2) begin
                                w_res[w_res_n[0]].kind = KIND_FIELD;
                                w_res_n = w_res_n + 2'd1;
                            end
                            handled = 1'b1;
                        end
                    end
                    if (!handled) begin
                        n_val_empty = 1'b0;
                        if (w_res_n != 2'd2) begin
                            w_res[w_res_n[0]].kind     = KIND_BYTE;
                            w_res[w_res_n[0]].out_byte = c;
                            w_res_n = w_res_n + 2'd1;
                        end
                    end
                end
            end
        end

        if (w_res_n == 2'd1) begin
            w_res[0].last_of_run = 1'b1;
        end else if (w_res_n == 2'd2) begin
            w_res[1].last_of_run = 1'b1;
        end
    end

    assign n_count = r_count + (w_accept ? 3'(w_res_n) : 3'd0) - (w_pop ? 3'd1 : 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sep  <= RST_FIRST_SEP;
            r_second_sep <= RST_SECOND_SEP;
            r_quote      <= RST_QUOTE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIRST_SEP:  r_first_sep  <= i_cfg_data;
                CFG_SECOND_SEP: r_second_sep <= i_cfg_data;
                CFG_QUOTE:      r_quote      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted    <= 1'b0;
            r_val_empty <= 1'b1;
            r_rec_open  <= 1'b0;
            r_crp       <= 1'b0;
            r_qcp       <= 1'b0;
        end else if (w_accept) begin
            r_quoted    <= n_quoted;
            r_val_empty <= n_val_empty;
            r_rec_open  <= n_rec_open;
            r_crp       <= n_crp;
            r_qcp       <= n_qcp;
        end
    end

    // Result queue: push up to two per request, pop one per cycle while the output is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= 2'd0;
            r_wr_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_count <= n_count;
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + w_res_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= w_res[0];
        end
        if (w_accept && w_res_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= w_res[1];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == 3'($past(r_count) + ($past(w_accept) ? 3'($past(w_res_n)) : 3'd0)
                               - ($past(w_pop) ? 3'd1 : 3'd0)))
        else $error("result count does not match pushes and pops");

    a_qcp_in_quotes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcp |-> r_quoted)
        else $error("held quote outside quoted mode");

    a_no_dual_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_crp && r_qcp))
        else $error("CR and quote held at once");

    a_crp_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_crp |-> r_rec_open)
        else $error("held CR without an open record");
`endif

endmodule

`default_nettype wire
